>>> rtl/ahtr_pkg.sv
package ahtr_pkg;

    // Telegram layout
    localparam int OFFSET_W = 9;
    localparam logic [OFFSET_W-1:0] HEADER_BYTES   = OFFSET_W'(5);
    localparam logic [OFFSET_W-1:0] CHECKSUM_BYTES = OFFSET_W'(2);
    localparam logic [OFFSET_W-1:0] LEN_POS        = OFFSET_W'(2);
    localparam logic [OFFSET_W-1:0] CMD_POS        = OFFSET_W'(4);
    localparam logic [7:0]          ACK_RESET      = 8'h06;

    typedef enum logic [1:0] {
        PH_ACK  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] overflow_count;
        logic [7:0]  payload_length;
        logic [7:0]  command_code;
        logic [7:0]  payload_byte;
        kind_t       kind;
    } rec_t;

endpackage

>>> rtl/ahtr_parser.sv
module ahtr_parser
    import ahtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       fifo_overflow,
    output logic       has_result,
    output rec_t       rec
);

    phase_t              phase_reg, phase_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          length_reg, length_next;
    logic [7:0]          command_reg, command_next;
    logic [15:0]         ovf_reg, ovf_next;
    logic [7:0]          ack_reg;

    logic [7:0]          pay_len;
    logic [OFFSET_W-1:0] pay_len_w;
    logic [OFFSET_W-1:0] offset_inc;

    // Length byte zero counts as an empty payload
    assign pay_len    = (length_reg == 8'd0) ? 8'd0 : length_reg - 8'd1;
    assign pay_len_w  = {1'b0, pay_len};
    assign offset_inc = offset_reg + OFFSET_W'(1);

    // Count overflow flags, hold at full scale
    assign ovf_next = (fifo_overflow && ovf_reg != 16'hFFFF) ? ovf_reg + 16'd1 : ovf_reg;

    // Next state and result
    always_comb begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        command_next = command_reg;
        has_result   = 1'b0;
        rec.kind           = KIND_PAYLOAD;
        rec.payload_byte   = 8'd0;
        rec.command_code   = command_reg;
        rec.payload_length = pay_len;
        rec.overflow_count = ovf_next;
        unique case (phase_reg)
            PH_HDR: begin
                if (offset_reg == LEN_POS) begin
                    length_next = rx_byte;
                end
                if (offset_reg == CMD_POS) begin
                    command_next = rx_byte;
                end
                offset_next = offset_inc;
                if (offset_inc >= HEADER_BYTES) begin
                    offset_next = '0;
                    phase_next  = PH_DATA;
                end
            end
            PH_DATA: begin
                offset_next = offset_inc;
                if (offset_reg < pay_len_w) begin
                    has_result       = 1'b1;
                    rec.payload_byte = rx_byte;
                end else if (offset_inc >= pay_len_w + CHECKSUM_BYTES) begin
                    offset_next = '0;
                    phase_next  = PH_ACK;
                    has_result  = 1'b1;
                    rec.kind    = KIND_DONE;
                end
            end
            default: begin
                // Waiting for acknowledge; the unused code behaves the same
                offset_next = '0;
                if (rx_byte == ack_reg) begin
                    phase_next = PH_HDR;
                end else begin
                    phase_next = PH_ACK;
                    has_result = 1'b1;
                    rec.kind   = KIND_ERROR;
                end
            end
        endcase
    end

    // Advance parser state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_ACK;
            offset_reg  <= '0;
            length_reg  <= 8'd0;
            command_reg <= 8'd0;
            ovf_reg     <= 16'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Hold the acknowledge value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_reg <= ACK_RESET;
        end else if (cfg_we) begin
            ack_reg <= cfg_wdata;
        end
    end

endmodule

>>> rtl/ack_header_telegram_receiver_core.sv
// Throughput: one input item per cycle; s_tready drops only while the skid register
//   is full. A two-entry output buffer (result register plus skid register)
//   registers each result item and lets input continue while one result waits on
//   m_tready.
// Reset: aresetn is synchronous, active low; it clears the parser state and the
//   overflow count, loads the acknowledge value 0x06 and empties the output buffer.
module ack_header_telegram_receiver_core
    import ahtr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] fifo_overflow
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] command_code,
                                   // [23:16] payload_length, [39:24] overflow_count
    output logic [1:0]  m_tuser    // [1:0] record_kind
);

    logic accept;
    logic has_result;
    rec_t rec;
    logic push, pop;

    logic out_valid_reg, skid_valid_reg;
    rec_t out_reg, skid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && has_result;
    assign pop      = out_valid_reg && m_tready;

    ahtr_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .rx_byte       (s_tdata),
        .fifo_overflow (s_tuser[0]),
        .has_result    (has_result),
        .rec           (rec)
    );

    // Output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= rec;
            end
        end else if (push) begin
            skid_reg <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.overflow_count, out_reg.payload_length,
                       out_reg.command_code, out_reg.payload_byte};

endmodule

>>> rtl/ahtr_checker.sv
module ahtr_checker
    import ahtr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Only defined record kinds leave the block
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == KIND_PAYLOAD || m_tuser == KIND_DONE
                  || m_tuser == KIND_ERROR)
        else $error("undefined record kind");

    // Payload bytes come only from a header with a nonempty payload
    a_paylen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[23:16] != 8'd0)
        else $error("payload item with empty payload length");

    // Completion records carry a zero data byte
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[7:0] == 8'd0)
        else $error("completion record with nonzero data byte");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ack_header_telegram_receiver_core ahtr_checker u_ahtr_checker (.*);
